[sv/lmi_pkg.sv]
// ----------------------------------------------------------------------------
// lmi_pkg
// Shared types, codes and helpers of the linear motion integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package lmi_pkg;

  // fraction bits of position, velocity and the verlet reciprocal
  localparam int FRAC_BITS = 16;

  // opcodes of an item beat
  localparam logic [1:0] OP_STEP      = 2'd0;
  localparam logic [1:0] OP_LOAD_PV   = 2'd1;
  localparam logic [1:0] OP_LOAD_PREV = 2'd2;

  // integration modes
  localparam logic [1:0] MODE_EULER  = 2'd0;
  localparam logic [1:0] MODE_SEMI   = 2'd1;
  localparam logic [1:0] MODE_RK4    = 2'd2;
  localparam logic [1:0] MODE_VERLET = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE       = 2'd0;
  localparam logic [1:0] CFG_STEP_DT    = 2'd1;
  localparam logic [1:0] CFG_INV_TWO_DT = 2'd2;

  // register reset values
  localparam logic [1:0]  MODE_RESET       = MODE_EULER;
  localparam int          DT_RESET         = 1049;
  localparam logic [15:0] STEP_DT_RESET    = 16'(DT_RESET);
  localparam logic [30:0] INV_TWO_DT_RESET = 31'd2048000;
  localparam logic [15:0] DTSQ_RESET       = 16'((DT_RESET * DT_RESET + 32768) >> 16);

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_pos_z;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic signed [31:0] load_vel_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               saturated;
  } result_t;

  // sequencer control shared by the three axis lanes
  typedef struct packed {
    logic       start;
    logic       step;
    logic       load_pv;
    logic       load_prev;
    logic       upd1;
    logic       mul2;
    logic       upd2;
    logic [1:0] mode;
  } lane_ctl_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               sat;
  } lane_res_t;

  // clamp to signed 32 bits, msb of the result is the clip flag
  function automatic logic [32:0] sat35(input logic signed [34:0] x);
    logic [32:0] r;
    if (x > 35'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (x < -35'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] sat65(input logic signed [64:0] x);
    logic [32:0] r;
    if (x > 65'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (x < -65'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/lmi_lane.sv]
// ----------------------------------------------------------------------------
// lmi_lane
// One axis: holds position, velocity and previous position and runs the
// multiply / update sequence of a step.
// ----------------------------------------------------------------------------
`default_nettype none

module lmi_lane (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lmi_pkg::lane_ctl_t  ctl,
  input  wire logic signed [31:0]  acc,
  input  wire logic signed [31:0]  load_pos,
  input  wire logic signed [31:0]  load_vel,
  input  wire logic [15:0]         step_dt,
  input  wire logic [15:0]         dtsq,
  input  wire logic [30:0]         inv_two_dt,
  output lmi_pkg::lane_res_t       res
);

  localparam int F = lmi_pkg::FRAC_BITS;
  localparam logic signed [64:0] RND_F  = 65'sd1 <<< (F - 1);
  localparam logic signed [48:0] RND_16 = 49'sd32768;
  localparam logic signed [48:0] RND_17 = 49'sd65536;

  logic signed [31:0] pos, vel, prev;
  logic               sat;
  logic signed [48:0] prod_a, prod_v, prod_q;
  logic signed [32:0] diff;
  logic signed [64:0] prod2;

  logic signed [16:0] dt_s, dtsq_s;
  logic signed [48:0] sum_a, sum_v, sum_q16, sum_q17;
  logic signed [32:0] ra, rv, rq16;
  logic signed [31:0] rq17;
  logic signed [34:0] vsum, np_sel;
  logic               nv_sat, np_sat;
  logic signed [31:0] nv_val, np_val;
  logic signed [32:0] op_a;
  logic signed [31:0] op_b;
  logic signed [64:0] sum2s, sum2v;
  logic signed [32:0] rn;
  logic signed [64-F:0] rv2;
  logic signed [34:0] ps_sum;
  logic               ps_sat, vv_sat;
  logic signed [31:0] ps_val, vv_val;

  always_comb begin
    dt_s    = signed'({1'b0, step_dt});
    dtsq_s  = signed'({1'b0, dtsq});

    sum_a   = prod_a + RND_16;
    sum_v   = prod_v + RND_16;
    sum_q16 = prod_q + RND_16;
    sum_q17 = prod_q + RND_17;
    ra      = sum_a[48:16];
    rv      = sum_v[48:16];
    rq16    = sum_q16[48:16];
    rq17    = sum_q17[48:17];

    vsum = 35'(vel) + 35'(ra);
    case (ctl.mode)
      lmi_pkg::MODE_RK4:    np_sel = 35'(pos) + 35'(rv) + 35'(rq17);
      lmi_pkg::MODE_VERLET: np_sel = (35'(pos) <<< 1) - 35'(prev) + 35'(rq16);
      default:              np_sel = 35'(pos) + 35'(rv);
    endcase
    {nv_sat, nv_val} = lmi_pkg::sat35(vsum);
    {np_sat, np_val} = lmi_pkg::sat35(np_sel);

    // shared second multiplier: v'*dt for semi-implicit, diff*inv for verlet
    if (ctl.mode == lmi_pkg::MODE_VERLET) begin
      op_a = diff;
      op_b = signed'({1'b0, inv_two_dt});
    end else begin
      op_a = 33'(vel);
      op_b = 32'(dt_s);
    end

    sum2s  = prod2 + 65'sd32768;
    sum2v  = prod2 + RND_F;
    rn     = sum2s[48:16];
    rv2    = sum2v[64:F];
    ps_sum = 35'(pos) + 35'(rn);
    {ps_sat, ps_val} = lmi_pkg::sat35(ps_sum);
    {vv_sat, vv_val} = lmi_pkg::sat65(65'(rv2));
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      prod_a <= 49'(acc) * 49'(dt_s);
      prod_v <= 49'(vel) * 49'(dt_s);
      prod_q <= 49'(acc) * 49'(dtsq_s);
    end
    if (ctl.mul2) begin
      prod2 <= 65'(op_a) * 65'(op_b);
    end
    if (ctl.upd1 && ctl.mode == lmi_pkg::MODE_VERLET) begin
      diff <= 33'(np_val) - 33'(prev);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      vel  <= '0;
      prev <= '0;
      sat  <= 1'b0;
    end else begin
      if (ctl.start) begin
        sat <= 1'b0;
      end
      if (ctl.load_pv) begin
        pos <= load_pos;
        vel <= load_vel;
      end
      if (ctl.load_prev) begin
        prev <= load_pos;
      end
      if (ctl.upd1) begin
        case (ctl.mode)
          lmi_pkg::MODE_SEMI: begin
            vel <= nv_val;
            sat <= sat | nv_sat;
          end
          lmi_pkg::MODE_VERLET: begin
            pos  <= np_val;
            prev <= pos;
            sat  <= sat | np_sat;
          end
          default: begin
            vel <= nv_val;
            pos <= np_val;
            sat <= sat | nv_sat | np_sat;
          end
        endcase
      end
      if (ctl.upd2) begin
        case (ctl.mode)
          lmi_pkg::MODE_SEMI: begin
            pos <= ps_val;
            sat <= sat | ps_sat;
          end
          lmi_pkg::MODE_VERLET: begin
            vel <= vv_val;
            sat <= sat | vv_sat;
          end
          default: begin
            sat <= sat;
          end
        endcase
      end
    end
  end

  assign res.pos = pos;
  assign res.vel = vel;
  assign res.sat = sat;

endmodule

`default_nettype wire

[sv/lmi_merge.sv]
// ----------------------------------------------------------------------------
// lmi_merge
// Gathers the three lanes into one result beat and holds it in the output
// register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lmi_merge (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire lmi_pkg::lane_res_t res_x,
  input  wire lmi_pkg::lane_res_t res_y,
  input  wire lmi_pkg::lane_res_t res_z,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output lmi_pkg::result_t        result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.pos_x     <= res_x.pos;
      result.pos_y     <= res_y.pos;
      result.pos_z     <= res_z.pos;
      result.vel_x     <= res_x.vel;
      result.vel_y     <= res_y.vel;
      result.vel_z     <= res_z.vel;
      result.saturated <= res_x.sat | res_y.sat | res_z.sat;
    end
  end

endmodule

`default_nettype wire

[sv/linear_motion_integrator_core.sv]
// ----------------------------------------------------------------------------
// linear_motion_integrator_core
// Three-axis position / velocity integrator in signed Q16.16 with explicit
// Euler, semi-implicit Euler, constant-acceleration RK4 and Verlet modes.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | payload
//  ---------+----------------------------------+----------------------------
//  item     | item_valid / item_ready          | lmi_pkg::item_t
//  result   | result_valid / result_ready      | lmi_pkg::result_t
//  config   | cfg_we, cfg_index                | cfg_data (31 bits)
//
//  a step beat runs product, update, second product, update, in that order;
//  the two chained multiplies per axis set this sequence
//  load and no-op beats go straight to the final state, then to the output register
//  the next item is taken in the cycle its predecessor moves to the output register
//  a stalled result holds the sequencer in its final state until the register frees
//  rst is synchronous: state and configuration return to their reset values
// ----------------------------------------------------------------------------
`default_nettype none

module linear_motion_integrator_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire lmi_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output lmi_pkg::result_t      result,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [30:0]      cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD1,
    ST_MUL2,
    ST_UPD2,
    ST_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [1:0]  mode;
  logic [15:0] step_dt;
  logic [15:0] dtsq;       // rounded step_dt squared, follows every step_dt write
  logic [30:0] inv_two_dt;
  logic [31:0] dtsq_full;

  logic               accept;
  logic               out_free;
  logic               load_out;
  lmi_pkg::lane_ctl_t ctl;
  lmi_pkg::lane_res_t res_x, res_y, res_z;

  // output register is free when empty or being drained this cycle
  assign out_free   = !result_valid || result_ready;
  assign load_out   = (state == ST_DONE) && out_free;
  assign item_ready = (state == ST_IDLE) || load_out;
  assign accept     = item_valid && item_ready;

  assign dtsq_full = 32'(cfg_data[15:0]) * 32'(cfg_data[15:0]) + 32'd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= lmi_pkg::MODE_RESET;
      step_dt    <= lmi_pkg::STEP_DT_RESET;
      dtsq       <= lmi_pkg::DTSQ_RESET;
      inv_two_dt <= lmi_pkg::INV_TWO_DT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lmi_pkg::CFG_MODE:       mode <= cfg_data[1:0];
        lmi_pkg::CFG_STEP_DT: begin
          step_dt <= cfg_data[15:0];
          dtsq    <= dtsq_full[31:16];
        end
        lmi_pkg::CFG_INV_TWO_DT: inv_two_dt <= cfg_data;
        default: begin
          mode <= mode;   // writes past the last register are dropped
        end
      endcase
    end
  end

  // sequencer: a step walks through the two product / update pairs,
  // loads and unknown opcodes go straight to the final state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (accept) begin
      state <= (item.opcode == lmi_pkg::OP_STEP) ? ST_UPD1 : ST_DONE;
    end else begin
      unique case (state)
        ST_IDLE: state <= ST_IDLE;
        ST_UPD1: state <= ST_MUL2;
        ST_MUL2: state <= ST_UPD2;
        ST_UPD2: state <= ST_DONE;
        ST_DONE: state <= out_free ? ST_IDLE : ST_DONE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    ctl.start     = accept;
    ctl.step      = accept && (item.opcode == lmi_pkg::OP_STEP);
    ctl.load_pv   = accept && (item.opcode == lmi_pkg::OP_LOAD_PV);
    ctl.load_prev = accept && (item.opcode == lmi_pkg::OP_LOAD_PREV);
    ctl.upd1      = (state == ST_UPD1);
    ctl.mul2      = (state == ST_MUL2);
    ctl.upd2      = (state == ST_UPD2);
    ctl.mode      = mode;
  end

  // one lane per axis, all driven by the same sequencer
  lmi_lane u_lane_x (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .acc        (item.acc_x),
    .load_pos   (item.load_pos_x),
    .load_vel   (item.load_vel_x),
    .step_dt    (step_dt),
    .dtsq       (dtsq),
    .inv_two_dt (inv_two_dt),
    .res        (res_x)
  );

  lmi_lane u_lane_y (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .acc        (item.acc_y),
    .load_pos   (item.load_pos_y),
    .load_vel   (item.load_vel_y),
    .step_dt    (step_dt),
    .dtsq       (dtsq),
    .inv_two_dt (inv_two_dt),
    .res        (res_y)
  );

  lmi_lane u_lane_z (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .acc        (item.acc_z),
    .load_pos   (item.load_pos_z),
    .load_vel   (item.load_vel_z),
    .step_dt    (step_dt),
    .dtsq       (dtsq),
    .inv_two_dt (inv_two_dt),
    .res        (res_z)
  );

  // merge the lanes into the result beat
  lmi_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (load_out),
    .res_x        (res_x),
    .res_y        (res_y),
    .res_z        (res_z),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

[sv/lmi_checker.sv]
// ----------------------------------------------------------------------------
// lmi_checker
// Port-level checks of the integrator core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lmi_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_ready,
  input wire lmi_pkg::item_t   item,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire lmi_pkg::result_t result
);

  // after reset nothing is pending and a beat can be taken
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!result_valid && item_ready))
    else $error("core not idle after reset");

  // a step keeps the item side closed while the axes compute
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.opcode == lmi_pkg::OP_STEP)
      |=> !item_ready ##1 !item_ready ##1 !item_ready)
    else $error("item taken during a step");

  // a stalled result beat stays
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("result beat dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> $stable(result))
    else $error("result payload changed while stalled");

endmodule

bind linear_motion_integrator_core lmi_checker u_lmi_checker (.*);

`default_nettype wire
